/* rtl/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants and codes for the pool free list allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int MAX_CHUNKS       = 8;
	localparam int MAX_CHUNK_BLOCKS = 64;

	localparam int ID_W        = 9;
	localparam int STACK_DEPTH = 1 << ID_W;
	localparam int FILL_W      = ID_W + 1;
	localparam int CB_W        = 7;
	localparam int ACT_W       = 2;
	localparam int ST_W        = 2;
	localparam int CHUNK_CNT_W = $clog2(MAX_CHUNKS + 1);

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [ST_W-1:0] ST_NULL_FREE = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL_DROP = 2'd3;

	localparam logic [0:0] REG_CHUNK_BLOCKS = 1'b0;

	localparam logic [CB_W-1:0] CHUNK_BLOCKS_RESET = 7'd64;

endpackage

/* rtl/pfa_req_if.sv */
// ----------------------------------------------------------------------------
// pfa_req_if
// Request channel: valid/ready handshake carrying one allocator command.
// ----------------------------------------------------------------------------
interface pfa_req_if
	import pfa_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [ID_W-1:0]  block_id;
	logic             block_present;

	modport source (output valid, output action, output block_id, output block_present,
		input ready);
	modport sink (input valid, input action, input block_id, input block_present,
		output ready);
endinterface

/* rtl/pfa_rsp_if.sv */
// ----------------------------------------------------------------------------
// pfa_rsp_if
// Response channel: valid/ready handshake carrying one allocator result.
// ----------------------------------------------------------------------------
interface pfa_rsp_if
	import pfa_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [ID_W-1:0]   granted_id;
	logic [FILL_W-1:0] free_count;

	modport source (output valid, output status, output granted_id, output free_count,
		input ready);
	modport sink (input valid, input status, input granted_id, input free_count,
		output ready);
endinterface

/* rtl/pfa_ram.sv */
// ----------------------------------------------------------------------------
// pfa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/pool_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// pool_free_list_allocator
// LIFO free stack of block ids held in one synchronous RAM, refilled a chunk
// at a time. The bottom of the stack after a clear or a chunk refill is kept
// as a virtual run (base + index) until pushes overwrite it, so no fill sweep.
// Free, clear and unused commands: result valid in the cycle after the transaction.
// Allocate: goes through S_POP, then the result is registered from stack RAM data.
// Throughput: one free/clear per cycle unless rsp stalls; allocate blocks in S_POP.
// Reset and clear are immediate: no memory clearing pass.
// ----------------------------------------------------------------------------
module pool_free_list_allocator
	import pfa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	pfa_req_if.sink               req,
	pfa_rsp_if.source             rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	typedef enum logic {S_IDLE, S_POP} state_t;

	state_t                 state_q;
	logic [CB_W-1:0]        chunk_blocks_q;
	logic [FILL_W-1:0]      fill_q;
	logic [CHUNK_CNT_W-1:0] chunks_q;
	logic [CB_W-1:0]        vlim_q;
	logic [ID_W-1:0]        vbase_q;

	logic [ST_W-1:0]        status_s1;
	logic                   grant_s1;
	logic                   virt_s1;
	logic [ID_W-1:0]        vval_s1;

	logic                   rsp_valid_q;
	logic [ST_W-1:0]        rsp_status_q;
	logic [ID_W-1:0]        rsp_granted_q;
	logic [FILL_W-1:0]      rsp_count_q;

	logic                   req_fire;
	logic                   rsp_load;
	logic                   cfg_write;
	logic [CB_W-1:0]        n_eff;
	logic [CHUNK_CNT_W+CB_W-1:0] prod;
	logic [FILL_W-1:0]      pop_idx;
	logic                   stack_full;

	logic                   mem_we;
	logic [ID_W-1:0]        mem_raddr;
	logic [ID_W-1:0]        mem_rdata;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_CHUNK_BLOCKS && paddr[1:0] == 2'b00)
		? {{(APB_DATA_W-CB_W){1'b0}}, chunk_blocks_q} : '0;

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign req_fire  = req.valid && req.ready;
	assign rsp_load  = (state_q == S_POP) || (req_fire && req.action != ACT_ALLOC);

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.granted_id = rsp_granted_q;
	assign rsp.free_count = rsp_count_q;

	always_comb begin
		if (chunk_blocks_q == '0) begin
			n_eff = CB_W'(1);
		end else if ({{(32-CB_W){1'b0}}, chunk_blocks_q} > 32'(MAX_CHUNK_BLOCKS)) begin
			n_eff = CB_W'(MAX_CHUNK_BLOCKS);
		end else begin
			n_eff = chunk_blocks_q;
		end
	end

	assign prod       = chunks_q * n_eff;
	assign pop_idx    = fill_q - FILL_W'(1);
	assign stack_full = (fill_q == FILL_W'(STACK_DEPTH));
	assign mem_raddr  = pop_idx[ID_W-1:0];
	assign mem_we     = req_fire && (req.action == ACT_FREE) && req.block_present
		&& !stack_full;

	pfa_ram #(
		.WIDTH (ID_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (fill_q[ID_W-1:0]),
		.wdata (req.block_id),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			chunk_blocks_q <= CHUNK_BLOCKS_RESET;
			fill_q         <= FILL_W'(CHUNK_BLOCKS_RESET);
			chunks_q       <= CHUNK_CNT_W'(1);
			vlim_q         <= CHUNK_BLOCKS_RESET;
			vbase_q        <= '0;
			status_s1      <= ST_OK;
			grant_s1       <= 1'b0;
			virt_s1        <= 1'b0;
			vval_s1        <= '0;
			rsp_valid_q    <= 1'b0;
			rsp_status_q   <= ST_OK;
			rsp_granted_q  <= '0;
			rsp_count_q    <= '0;
		end else begin
			if (cfg_write && paddr[2] == REG_CHUNK_BLOCKS) begin
				chunk_blocks_q <= pwdata[CB_W-1:0];
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						case (req.action)
							ACT_ALLOC: begin
								state_q <= S_POP;
								if (fill_q == '0) begin
									if ({{(32-CHUNK_CNT_W){1'b0}}, chunks_q} >= 32'(MAX_CHUNKS)) begin
										status_s1 <= ST_EXHAUSTED;
										grant_s1  <= 1'b0;
									end else begin
										// refill: next chunk becomes the virtual run
										status_s1 <= ST_OK;
										grant_s1  <= 1'b1;
										virt_s1   <= 1'b1;
										vval_s1   <= ID_W'(prod) + ID_W'(n_eff) - ID_W'(1);
										vbase_q   <= ID_W'(prod);
										vlim_q    <= n_eff;
										fill_q    <= FILL_W'(n_eff) - FILL_W'(1);
										chunks_q  <= chunks_q + CHUNK_CNT_W'(1);
									end
								end else begin
									status_s1 <= ST_OK;
									grant_s1  <= 1'b1;
									virt_s1   <= pop_idx < FILL_W'(vlim_q);
									vval_s1   <= vbase_q + pop_idx[ID_W-1:0];
									fill_q    <= pop_idx;
								end
							end
							ACT_FREE: begin
								rsp_granted_q <= '0;
								if (!req.block_present) begin
									rsp_status_q <= ST_NULL_FREE;
									rsp_count_q  <= fill_q;
								end else if (stack_full) begin
									rsp_status_q <= ST_FULL_DROP;
									rsp_count_q  <= fill_q;
								end else begin
									rsp_status_q <= ST_OK;
									rsp_count_q  <= fill_q + FILL_W'(1);
									fill_q       <= fill_q + FILL_W'(1);
									if (fill_q < FILL_W'(vlim_q)) begin
										vlim_q <= fill_q[CB_W-1:0];
									end
								end
							end
							ACT_CLEAR: begin
								fill_q        <= FILL_W'(n_eff);
								vlim_q        <= n_eff;
								vbase_q       <= '0;
								chunks_q      <= CHUNK_CNT_W'(1);
								rsp_status_q  <= ST_OK;
								rsp_granted_q <= '0;
								rsp_count_q   <= FILL_W'(n_eff);
							end
							default: begin
								rsp_status_q  <= ST_OK;
								rsp_granted_q <= '0;
								rsp_count_q   <= fill_q;
							end
						endcase
					end
				end
				S_POP: begin
					state_q       <= S_IDLE;
					rsp_status_q  <= status_s1;
					rsp_count_q   <= fill_q;
					if (!grant_s1) begin
						rsp_granted_q <= '0;
					end else if (virt_s1) begin
						rsp_granted_q <= vval_s1;
					end else begin
						rsp_granted_q <= mem_rdata;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
